// ----- sv/lzsd_pkg.sv -----
// Shared constants and types of the LZSS ring decoder.
package lzsd_pkg;

	// Ring history geometry.
	localparam int RING_SIZE    = 4096;
	localparam int RING_AW      = $clog2(RING_SIZE);
	localparam int MATCH_LIMIT  = 16;
	localparam int MATCH_OFFSET = 2;

	// Field widths.
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 24;
	localparam int FLAG_W  = 9;
	localparam int RUN_W   = 5;

	// Ring position where a stream starts writing, and the last entry the
	// stream-start fill covers.
	localparam logic [RING_AW-1:0] WP_START  = RING_AW'(RING_SIZE - MATCH_LIMIT);
	localparam logic [RING_AW-1:0] FILL_LAST = RING_AW'(RING_SIZE - MATCH_LIMIT - 1);
	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_SIZE - 1);

	localparam logic [BYTE_W-1:0]  SPACE_BYTE  = 8'h20;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 24'd65536;
	localparam logic [RUN_W-1:0]   RUN_EXTRA   = RUN_W'(MATCH_OFFSET + 1);

	// What the next compressed byte is expected to be.
	typedef enum logic [1:0] {
		PH_FLAG   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	// Control states of the decoder.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_FILL,
		ST_IDLE,
		ST_BYTE,
		ST_COPY
	} state_t;

endpackage

// ----- sv/lzsd_ifs.sv -----
// Handshake channels of the LZSS ring decoder: input items, result items, configuration.
interface lzsd_stream_if;
	logic                       valid;
	logic                       ready;
	logic [lzsd_pkg::BYTE_W-1:0] in_byte;
	logic                       start_of_stream;

	modport source (output valid, output in_byte, output start_of_stream, input ready);
	modport sink (input valid, input in_byte, input start_of_stream, output ready);
endinterface

interface lzsd_result_if;
	logic                       valid;
	logic                       ready;
	logic [lzsd_pkg::BYTE_W-1:0] out_byte;
	logic                       last_of_run;
	logic                       limit_reached;

	modport source (output valid, output out_byte, output last_of_run,
		output limit_reached, input ready);
	modport sink (input valid, input out_byte, input last_of_run,
		input limit_reached, output ready);
endinterface

interface lzsd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lzsd_pkg::COUNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/lzsd_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module lzsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; a read of the entry written in the same cycle returns old data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/lzss_ring_decoder_core.sv -----
// Top level of the LZSS ring decoder: byte parser, copy engine and ring history memory.
//
// The decoder takes one compressed byte per input item and delivers decoded bytes one per
// result item through an output register. A flag byte, a literal and the first byte of a
// match are each handled in the cycle they are accepted; a literal that meets a full output
// register is parked and goes out once the register frees. The second byte of a match of n
// bytes (3 to 18) holds the input until its copy ends: the copy reads the 4096-entry ring
// memory through a registered read port, once per cycle while the output is not stalled,
// and writes each byte back at the write position in the same cycle as it is emitted,
// forwarding a byte written in the cycle its own entry is read. After reset the block
// sweeps the whole ring before it takes its first item. An item with start_of_stream set
// starts a fill of ring entries 0 to 4079 with spaces; its byte is handled after the fill.
// The output limit is written through the configuration channel, which is always ready.
module lzss_ring_decoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	lzsd_stream_if.sink          in_items,
	lzsd_result_if.source        out_items,
	lzsd_cfg_if.sink             cfg
);

	lzsd_pkg::state_t state_q, state_nx;

	logic [lzsd_pkg::RING_AW-1:0] fill_q;
	logic [lzsd_pkg::RING_AW-1:0] wp_q;
	logic [lzsd_pkg::RING_AW-1:0] pos_q;
	logic [lzsd_pkg::FLAG_W-1:0]  flag_q;
	lzsd_pkg::phase_t             phase_q;
	logic [lzsd_pkg::BYTE_W-1:0]  mlow_q;
	logic [lzsd_pkg::BYTE_W-1:0]  held_q;
	logic [lzsd_pkg::COUNT_W-1:0] count_q;
	logic [lzsd_pkg::COUNT_W-1:0] limit_q;
	logic                         finished_q;
	logic [lzsd_pkg::RUN_W-1:0]   rem_issue_q;
	logic [lzsd_pkg::RUN_W-1:0]   rem_emit_q;

	logic                         valid_s1;
	logic                         fwd_s1;
	logic [lzsd_pkg::BYTE_W-1:0]  fwd_data_s1;
	logic                         hold_sel_q;
	logic [lzsd_pkg::BYTE_W-1:0]  hold_q;

	logic                         out_valid_q;
	logic [lzsd_pkg::BYTE_W-1:0]  out_byte_q;
	logic                         out_last_q;
	logic                         out_limit_q;

	logic [lzsd_pkg::BYTE_W-1:0]  ram_rdata;
	logic                         ram_we;
	logic [lzsd_pkg::RING_AW-1:0] ram_waddr;
	logic [lzsd_pkg::BYTE_W-1:0]  ram_wdata;

	logic [lzsd_pkg::BYTE_W-1:0]  cur_byte;
	logic                         can_emit;
	logic                         acc;
	logic                         acc_sos;
	logic                         proc_lit;
	logic                         stall;
	logic                         park;
	logic                         proc_go;
	logic                         proc_live;
	logic                         lit_emit;
	logic                         copy_setup;
	logic                         emit_copy;
	logic                         emit_now;
	logic                         issue;
	logic                         copy_done;
	logic                         fill_active;
	logic [lzsd_pkg::BYTE_W-1:0]  s1_data;
	logic [lzsd_pkg::BYTE_W-1:0]  emit_data;
	logic                         emit_last;
	logic [lzsd_pkg::COUNT_W-1:0] count_inc;
	logic                         hit;
	logic [lzsd_pkg::FLAG_W-1:0]  flag_shifted;
	lzsd_pkg::phase_t             phase_after;
	logic [lzsd_pkg::RING_AW-1:0] match_pos;
	logic [lzsd_pkg::RUN_W-1:0]   match_len;

	// Byte under decode: straight from the channel when idle, else the parked byte.
	assign cur_byte = (state_q == lzsd_pkg::ST_BYTE) ? held_q : in_items.in_byte;

	// Flag consumption and match fields.
	assign flag_shifted = {1'b0, flag_q[lzsd_pkg::FLAG_W-1:1]};
	assign phase_after  = (flag_shifted[lzsd_pkg::FLAG_W-1:1] == '0) ?
		lzsd_pkg::PH_FLAG : lzsd_pkg::PH_FIRST;
	assign match_pos    = {cur_byte[7:4], mlow_q};
	assign match_len    = lzsd_pkg::RUN_W'(cur_byte[3:0]) + lzsd_pkg::RUN_EXTRA;

	// Count and limit check for the byte going out this cycle.
	assign count_inc = count_q + lzsd_pkg::COUNT_W'(1);
	assign hit       = (count_inc == limit_q);

	// Copy read data: held, forwarded from the write of the read cycle, or from the ring.
	assign s1_data = hold_sel_q ? hold_q : (fwd_s1 ? fwd_data_s1 : ram_rdata);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			lzsd_pkg::ST_INIT: begin
				if (fill_q == lzsd_pkg::RING_LAST) state_nx = lzsd_pkg::ST_IDLE;
			end
			lzsd_pkg::ST_FILL: begin
				if (fill_q == lzsd_pkg::FILL_LAST) state_nx = lzsd_pkg::ST_BYTE;
			end
			lzsd_pkg::ST_IDLE: begin
				if (acc_sos) state_nx = lzsd_pkg::ST_FILL;
				else if (park) state_nx = lzsd_pkg::ST_BYTE;
				else if (copy_setup) state_nx = lzsd_pkg::ST_COPY;
			end
			lzsd_pkg::ST_BYTE: begin
				if (copy_setup) state_nx = lzsd_pkg::ST_COPY;
				else if (proc_go) state_nx = lzsd_pkg::ST_IDLE;
			end
			lzsd_pkg::ST_COPY: begin
				if (copy_done) state_nx = lzsd_pkg::ST_IDLE;
			end
			default: state_nx = lzsd_pkg::ST_INIT;
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		can_emit    = !out_valid_q || out_items.ready;
		in_items.ready = (state_q == lzsd_pkg::ST_IDLE);
		acc         = (state_q == lzsd_pkg::ST_IDLE) && in_items.valid;
		acc_sos     = acc && in_items.start_of_stream;
		proc_lit    = (phase_q == lzsd_pkg::PH_FIRST) && flag_q[0];
		stall       = proc_lit && !finished_q && !can_emit;
		park        = acc && !in_items.start_of_stream && stall;
		proc_go     = ((acc && !in_items.start_of_stream) ||
			(state_q == lzsd_pkg::ST_BYTE)) && !stall;
		proc_live   = proc_go && !finished_q;
		lit_emit    = proc_live && proc_lit;
		copy_setup  = proc_live && (phase_q == lzsd_pkg::PH_SECOND);
		emit_copy   = (state_q == lzsd_pkg::ST_COPY) && valid_s1 && can_emit;
		emit_now    = lit_emit || emit_copy;
		emit_data   = lit_emit ? cur_byte : s1_data;
		emit_last   = lit_emit || (rem_emit_q == lzsd_pkg::RUN_W'(1)) || hit;
		copy_done   = emit_copy && ((rem_emit_q == lzsd_pkg::RUN_W'(1)) || hit);
		issue       = (state_q == lzsd_pkg::ST_COPY) && (rem_issue_q != '0) &&
			(!valid_s1 || emit_copy) && !copy_done;
		fill_active = (state_q == lzsd_pkg::ST_INIT) || (state_q == lzsd_pkg::ST_FILL);
	end

	// Ring write port: sweep data during fills, decoded bytes otherwise.
	always_comb begin
		ram_we    = fill_active || emit_now;
		ram_waddr = fill_active ? fill_q : wp_q;
		if (fill_active) begin
			ram_wdata = (fill_q > lzsd_pkg::FILL_LAST) ? '0 : lzsd_pkg::SPACE_BYTE;
		end else begin
			ram_wdata = emit_data;
		end
	end

	lzsd_ram #(
		.WIDTH (lzsd_pkg::BYTE_W),
		.DEPTH (lzsd_pkg::RING_SIZE)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// State register and fill sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzsd_pkg::ST_INIT;
			fill_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (acc_sos) fill_q <= '0;
			else if (fill_active) fill_q <= fill_q + lzsd_pkg::RING_AW'(1);
		end
	end

	// Parser state, write position, byte count and limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= lzsd_pkg::WP_START;
			flag_q     <= '0;
			phase_q    <= lzsd_pkg::PH_FLAG;
			mlow_q     <= '0;
			count_q    <= '0;
			finished_q <= 1'b0;
			limit_q    <= lzsd_pkg::LIMIT_RESET;
		end else begin
			if (cfg.valid) limit_q <= cfg.data;
			if (acc_sos) begin
				wp_q       <= lzsd_pkg::WP_START;
				flag_q     <= '0;
				phase_q    <= lzsd_pkg::PH_FLAG;
				mlow_q     <= '0;
				count_q    <= '0;
				finished_q <= 1'b0;
			end else begin
				if (proc_live) begin
					case (phase_q)
						lzsd_pkg::PH_FIRST: begin
							if (flag_q[0]) begin
								flag_q  <= flag_shifted;
								phase_q <= phase_after;
							end else begin
								mlow_q  <= cur_byte;
								phase_q <= lzsd_pkg::PH_SECOND;
							end
						end
						lzsd_pkg::PH_SECOND: begin
							flag_q  <= flag_shifted;
							phase_q <= phase_after;
						end
						default: begin
							flag_q  <= {1'b1, cur_byte};
							phase_q <= lzsd_pkg::PH_FIRST;
						end
					endcase
				end
				if (emit_now) begin
					wp_q    <= wp_q + lzsd_pkg::RING_AW'(1);
					count_q <= count_inc;
					if (hit) finished_q <= 1'b1;
				end
			end
		end
	end

	// Parked byte of an item waiting for a fill or a free output register.
	always_ff @(posedge clk) begin
		if (acc_sos || park) held_q <= in_items.in_byte;
	end

	// Copy engine control: read issue and emit counters, read stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_issue_q <= '0;
			rem_emit_q  <= '0;
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			hold_sel_q  <= 1'b0;
		end else begin
			if (copy_setup) begin
				rem_issue_q <= match_len;
				rem_emit_q  <= match_len;
				valid_s1    <= 1'b0;
				fwd_s1      <= 1'b0;
				hold_sel_q  <= 1'b0;
			end else if (issue) begin
				rem_issue_q <= rem_issue_q - lzsd_pkg::RUN_W'(1);
				valid_s1    <= 1'b1;
				fwd_s1      <= emit_copy && (pos_q == wp_q);
				hold_sel_q  <= 1'b0;
			end else if (emit_copy) begin
				valid_s1    <= 1'b0;
			end else if (valid_s1) begin
				hold_sel_q  <= 1'b1;
			end
			if (emit_copy) rem_emit_q <= rem_emit_q - lzsd_pkg::RUN_W'(1);
		end
	end

	// Copy engine data: read address, forwarded byte and stalled read data.
	always_ff @(posedge clk) begin
		if (copy_setup) pos_q <= match_pos;
		else if (issue) pos_q <= pos_q + lzsd_pkg::RING_AW'(1);
		if (issue) fwd_data_s1 <= emit_data;
		if (valid_s1 && !emit_copy && !hold_sel_q) hold_q <= s1_data;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now) out_valid_q <= 1'b1;
			else if (out_items.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			out_byte_q  <= emit_data;
			out_last_q  <= emit_last;
			out_limit_q <= hit;
		end
	end

	assign out_items.valid         = out_valid_q;
	assign out_items.out_byte      = out_byte_q;
	assign out_items.last_of_run   = out_last_q;
	assign out_items.limit_reached = out_limit_q;
	assign cfg.ready               = 1'b1;

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_items.ready) |-> !emit_now)
		else $error("output register overwritten while a result waits");

	// Nothing is decoded once the limit has been reached.
	a_quiet_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> !emit_now)
		else $error("byte emitted after the output limit was reached");

	// The byte that reaches the limit always ends its run.
	a_limit_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_limit_q) |-> out_last_q)
		else $error("limit byte without end of run");

endmodule

// ----- sim/lzss_ring_decoder_core_test.sv -----
// Self-checking testbench of the LZSS ring decoder core: directed table, then random streams.
`timescale 1ns / 1ps

module lzss_ring_decoder_core_test;

	// Run control.
	localparam int    SETTLE_CYCLES = 4200;
	localparam int    LONG_HOLD     = 400;
	localparam int    RANDOM_ITEMS  = 190;
	localparam longint TIMEOUT_NS   = 64'd20_000_000;

	// One decoded byte as it leaves the block.
	typedef struct packed {
		logic [lzsd_pkg::BYTE_W-1:0] data;
		logic                        last;
		logic                        lim;
	} dec_byte_t;

	// One row of the directed table: an input item or a write of the output limit.
	typedef enum bit {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t                    kind;
		logic [lzsd_pkg::COUNT_W-1:0] val;
		logic                         sos;
		bit                           typed;
		dec_byte_t                    want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lzsd_stream_if in_if ();
	lzsd_result_if out_if ();
	lzsd_cfg_if    cfg_if ();

	lzss_ring_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_items  (in_if),
		.out_items (out_if),
		.cfg       (cfg_if)
	);

	// Decoder state as the testbench sees it.
	logic [lzsd_pkg::BYTE_W-1:0]  hist [lzsd_pkg::RING_SIZE];
	logic [lzsd_pkg::RING_AW-1:0] wr_pos;
	logic [lzsd_pkg::FLAG_W-1:0]  flag_bits;
	lzsd_pkg::phase_t             phase;
	logic [lzsd_pkg::BYTE_W-1:0]  match_lo;
	logic [lzsd_pkg::COUNT_W-1:0] out_cnt;
	logic                         stopped;
	logic [lzsd_pkg::COUNT_W-1:0] lim_reg;

	dec_byte_t step_bytes[$];
	dec_byte_t due_bytes[$];

	int        errors = 0;
	int        item_cnt = 0;
	int        burst_left = 0;
	bit        hold_req;
	bit        offer_typed;
	dec_byte_t offer_want;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A new stream refills the lower ring with spaces and clears the parser.
	task automatic start_stream();
		for (int i = 0; i < lzsd_pkg::RING_SIZE - lzsd_pkg::MATCH_LIMIT; i++)
			hist[i] = lzsd_pkg::SPACE_BYTE;
		wr_pos    = lzsd_pkg::WP_START;
		flag_bits = '0;
		phase     = lzsd_pkg::PH_FLAG;
		match_lo  = '0;
		out_cnt   = '0;
		stopped   = 1'b0;
	endtask

	// Emits one byte, writes it back into the ring and checks the limit.
	task automatic emit(input logic [lzsd_pkg::BYTE_W-1:0] c, output logic hit);
		dec_byte_t r;
		hist[wr_pos] = c;
		wr_pos  = wr_pos + 1'b1;
		out_cnt = out_cnt + 1'b1;
		hit     = (out_cnt == lim_reg);
		r.data  = c;
		r.last  = 1'b0;
		r.lim   = hit;
		step_bytes.push_back(r);
		if (hit)
			stopped = 1'b1;
	endtask

	task automatic next_flag();
		flag_bits = flag_bits >> 1;
		phase     = (flag_bits <= 9'd1) ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_FIRST;
	endtask

	// Works out the bytes that one compressed byte produces.
	task automatic decode_byte(input logic [lzsd_pkg::BYTE_W-1:0] b, input logic sos);
		logic [lzsd_pkg::RING_AW-1:0] src;
		int                           run;
		logic                         hit;
		step_bytes.delete();
		hit = 1'b0;
		if (sos)
			start_stream();
		if (stopped)
			return;
		case (phase)
			lzsd_pkg::PH_FIRST: begin
				if (flag_bits[0]) begin
					emit(b, hit);
					next_flag();
				end else begin
					match_lo = b;
					phase    = lzsd_pkg::PH_SECOND;
				end
			end
			lzsd_pkg::PH_SECOND: begin
				src = {b[7:4], match_lo};
				run = int'(b[3:0]) + lzsd_pkg::MATCH_OFFSET + 1;
				for (int k = 0; k < run && !hit; k++)
					emit(hist[src + lzsd_pkg::RING_AW'(k)], hit);
				next_flag();
			end
			default: begin
				flag_bits = {1'b1, b};
				phase     = lzsd_pkg::PH_FIRST;
			end
		endcase
		if (step_bytes.size() > 0)
			step_bytes[step_bytes.size() - 1].last = 1'b1;
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic step_row_t row(row_kind_t kind, logic [lzsd_pkg::COUNT_W-1:0] val,
			logic sos, bit typed, logic [lzsd_pkg::BYTE_W-1:0] want_data, logic want_lim);
		step_row_t r;
		r.kind      = kind;
		r.val       = val;
		r.sos       = sos;
		r.typed     = typed;
		r.want.data = want_data;
		r.want.last = 1'b1;
		r.want.lim  = want_lim;
		return r;
	endfunction

	// Checks every accepted result, then tracks limit writes and accepted input items.
	always @(posedge clk) begin
		dec_byte_t want;
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				if (due_bytes.size() == 0) begin
					$error("result with none expected: out_byte %0h", out_if.out_byte);
					errors++;
				end else begin
					want = due_bytes.pop_front();
					check_field("out_byte", want.data, out_if.out_byte);
					check_field("last_of_run", want.last, out_if.last_of_run);
					check_field("limit_reached", want.lim, out_if.limit_reached);
				end
			end
			if (cfg_if.valid && cfg_if.ready)
				lim_reg = cfg_if.data;
			if (in_if.valid && in_if.ready) begin
				item_cnt++;
				decode_byte(in_if.in_byte, in_if.start_of_stream);
				if (offer_typed)
					due_bytes.push_back(offer_want);
				else
					foreach (step_bytes[i])
						due_bytes.push_back(step_bytes[i]);
			end
		end
	end

	// The receiver stalls on a changing pattern, with one long hold-off on request.
	initial begin
		int            hold_left;
		int            pat_age;
		logic [15:0]   pat_word;
		hold_left = 0;
		pat_age   = 0;
		pat_word  = '1;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_if.ready <= 1'b0;
			end else begin
				if (pat_age == 0) begin
					case ($urandom_range(0, 3))
						0: pat_word = '1;
						1: pat_word = 16'($urandom);
						2: pat_word = 16'($urandom) | 16'($urandom);
						default: pat_word = 16'($urandom) & 16'($urandom);
					endcase
					pat_age = 16;
				end
				out_if.ready <= pat_word[pat_age - 1];
				pat_age--;
			end
		end
	end

	// Offers one item, in bursts with random gaps, and waits until it is taken.
	task automatic offer(input logic [lzsd_pkg::BYTE_W-1:0] b, input logic sos,
			input bit typed, input dec_byte_t want);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = 0;
				5, 6, 7: gap = $urandom_range(1, 3);
				8: gap = $urandom_range(4, 10);
				default: gap = $urandom_range(11, 30);
			endcase
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_if.valid           <= 1'b1;
		in_if.in_byte         <= b;
		in_if.start_of_stream <= sos;
		offer_typed           <= typed;
		offer_want            <= want;
		do @(posedge clk); while (!in_if.ready);
		burst_left--;
	endtask

	// Stops offering and waits until every expected byte has come out.
	task automatic settle();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (due_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Limit writes happen only once the block has gone quiet, fill included.
	task automatic set_limit(input logic [lzsd_pkg::COUNT_W-1:0] v);
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	// One random stream: mostly well-formed flag groups, with stream restarts as noise.
	task automatic random_stream(input int n_groups, input bit with_hold, input bit with_pause);
		logic [lzsd_pkg::BYTE_W-1:0]  flags;
		logic [lzsd_pkg::BYTE_W-1:0]  len;
		logic [lzsd_pkg::RING_AW-1:0] pos_est;
		logic [lzsd_pkg::RING_AW-1:0] src;
		int                           bit_i;
		dec_byte_t                    none;
		none    = '0;
		flags   = 8'($urandom);
		offer(flags, 1'b1, 1'b0, none);
		bit_i   = 0;
		pos_est = lzsd_pkg::WP_START;
		for (int k = 0; k < n_groups; k++) begin
			if (with_hold && k == n_groups / 2)
				hold_req = 1'b1;
			if (with_pause && k == n_groups / 2)
				settle();
			if ($urandom_range(0, 39) == 0) begin
				flags = 8'($urandom);
				offer(flags, 1'b1, 1'b0, none);
				bit_i   = 0;
				pos_est = lzsd_pkg::WP_START;
			end else if (bit_i == 8) begin
				flags = 8'($urandom);
				offer(flags, 1'b0, 1'b0, none);
				bit_i = 0;
			end else if (flags[bit_i]) begin
				offer(8'($urandom), 1'b0, 1'b0, none);
				pos_est = pos_est + 1'b1;
				bit_i++;
			end else begin
				// Favor copies close behind the write position and from the kept top entries.
				case ($urandom_range(0, 9))
					0, 1, 2: src = pos_est - lzsd_pkg::RING_AW'($urandom_range(1, 3));
					3: src = lzsd_pkg::RING_AW'($urandom_range(
						lzsd_pkg::RING_SIZE - lzsd_pkg::MATCH_LIMIT, lzsd_pkg::RING_SIZE - 1));
					4: src = lzsd_pkg::RING_AW'($urandom_range(0, 20));
					default: src = lzsd_pkg::RING_AW'($urandom);
				endcase
				len = 8'($urandom_range(0, 15));
				offer(src[7:0], 1'b0, 1'b0, none);
				if ($urandom_range(0, 19) == 0) begin
					// Restart the stream between the two bytes of a match.
					flags = 8'($urandom);
					offer(flags, 1'b1, 1'b0, none);
					bit_i   = 0;
					pos_est = lzsd_pkg::WP_START;
				end else begin
					offer({src[11:8], len[3:0]}, 1'b0, 1'b0, none);
					pos_est = pos_est + lzsd_pkg::RING_AW'(len) +
						lzsd_pkg::RING_AW'(lzsd_pkg::MATCH_OFFSET + 1);
					bit_i++;
				end
			end
		end
	endtask

	// Main sequence: reset, directed table, random streams, drain.
	initial begin
		step_row_t                    script[$];
		logic [lzsd_pkg::COUNT_W-1:0] lim_pick;
		int                           base;
		int                           s;
		arst_n                = 1'b0;
		in_if.valid           = 1'b0;
		in_if.in_byte         = '0;
		in_if.start_of_stream = 1'b0;
		cfg_if.valid          = 1'b0;
		cfg_if.data           = '0;
		offer_typed           = 1'b0;
		offer_want            = '0;
		hold_req              = 1'b0;
		for (int i = 0; i < lzsd_pkg::RING_SIZE; i++)
			hist[i] = '0;
		start_stream();
		lim_reg = lzsd_pkg::LIMIT_RESET;

		// Directed rows: literals at the byte extremes, copies across the ring end,
		// a copy fed by the entry just written, restarts, and limits hit early.
		script.push_back(row(ROW_CFG,  24'hFFFFFF, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h0F, 1'b1, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h00, 1'b0, 1'b1, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hFF, 1'b0, 1'b1, 8'hFF, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h5A, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hA5, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hF0, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hFF, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h05, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h02, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h00, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h00, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hFF, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hF0, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h01, 1'b1, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h42, 1'b0, 1'b1, 8'h42, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hF0, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hFF, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_CFG,  24'd1, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'hFF, 1'b1, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h3C, 1'b0, 1'b1, 8'h3C, 1'b1));
		script.push_back(row(ROW_ITEM, 24'h77, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h00, 1'b1, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h00, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h0F, 1'b0, 1'b1, lzsd_pkg::SPACE_BYTE, 1'b1));
		script.push_back(row(ROW_CFG,  24'd5, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h00, 1'b1, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h10, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h0F, 1'b0, 1'b0, 8'h00, 1'b0));
		script.push_back(row(ROW_ITEM, 24'h99, 1'b0, 1'b0, 8'h00, 1'b0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				set_limit(script[i].val);
			else
				offer(script[i].val[7:0], script[i].sos, script[i].typed, script[i].want);
		end

		// Random streams; the first one gets the long receiver hold-off, the second a drain.
		set_limit(lzsd_pkg::LIMIT_RESET);
		base = item_cnt;
		s    = 0;
		while (item_cnt - base < RANDOM_ITEMS) begin
			if (s > 1 && $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: lim_pick = lzsd_pkg::COUNT_W'($urandom_range(1, 40));
					1: lim_pick = lzsd_pkg::COUNT_W'($urandom_range(41, 300));
					2: lim_pick = '1;
					3: lim_pick = lzsd_pkg::COUNT_W'($urandom_range(1, 24'hFFFFFF));
					default: lim_pick = lzsd_pkg::LIMIT_RESET;
				endcase
				set_limit(lim_pick);
			end
			random_stream((s == 0) ? $urandom_range(30, 40) : $urandom_range(8, 40),
				s == 0, s == 1);
			s++;
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
